>>> src/pacd_pkg.sv
// Package for the Persian arithmetic calendar converter.
// Holds shared types, calendar constants and month offset helpers.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pacd_pkg;

  localparam int MID_DEPTH_DEF = 4;
  localparam int OUT_DEPTH_DEF = 16;

  localparam logic [19:0] EPOCH_RST = 20'd226896;

  localparam int CYC_YEARS = 2820;
  localparam int CYC_DAYS  = 1029983;
  localparam int YEAR_DIV  = 46751;
  localparam int YEAR_OFS  = 46878;
  localparam int YEAR_BIAS = 33840;     // 12 times CYC_YEARS
  localparam int DAY_BIAS  = 18366569;  // 18 times CYC_DAYS less day offset of year 475
  localparam int FIX_BIAS  = 172758;

  localparam logic [12:0] RCP_CYC_Y = 13'((64'd1 << 24) / 64'd2820);
  localparam logic [20:0] RCP_CYC_D = 21'((64'd1 << 40) / 64'd1029983);
  localparam logic [24:0] RCP_YEAR  = 25'((64'd1 << 40) / 64'd46751);

  typedef enum logic {
    REQ_TO_DAY  = 1'b0,
    REQ_TO_DATE = 1'b1
  } req_t;

  typedef struct packed {
    req_t               req_type;
    logic signed [24:0] rd;
    logic [3:0]         month;
    logic [4:0]         day;
    logic [25:0]        num;
  } mid_t;

  typedef struct packed {
    logic signed [24:0] result_day;
    logic signed [15:0] result_year;
    logic [3:0]         result_month;
    logic [4:0]         result_dom;
    logic               leap_year;
    logic               range_error;
  } res_t;

  // days before the first of month m, formula applied for any code
  function automatic logic signed [9:0] month_ofs(input logic [3:0] m);
    int mi;
    mi = int'(m);
    if (mi <= 7) begin
      return 10'(31 * mi - 31);
    end else begin
      return 10'(30 * mi - 24);
    end
  endfunction

  function automatic logic [3:0] month_of(input logic [8:0] doy);
    logic [3:0] cnt;
    int         thr;
    cnt = 4'd1;
    for (int k = 1; k <= 11; k++) begin
      thr = (k <= 6) ? 31 * k : 186 + 30 * (k - 6);
      if (doy > 9'(thr)) begin
        cnt = cnt + 4'd1;
      end
    end
    return cnt;
  endfunction

endpackage

`default_nettype wire

>>> src/pacd_fifo.sv
// Small register queue used between front and back and on the result side.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

module pacd_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      rdata,
  output logic                  empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             wr, rd;

  assign full  = (cnt_r == CW'(DEPTH));
  assign empty = (cnt_r == '0);
  assign wr    = push && !full;
  assign rd    = pop && !empty;
  assign rdata = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (wr) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (rd) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    case ({wr, rd})
      2'b10:   cnt_nxt = cnt_r + CW'(1);
      2'b01:   cnt_nxt = cnt_r - CW'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH))
    else $error("queue count above depth");

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full))
    else $error("push into full queue");

  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (rd && !wr) |=> (cnt_r == $past(cnt_r) - CW'(1)))
    else $error("queue count did not drop on read");

endmodule

`default_nettype wire

>>> src/pacd_front.sv
// Front end: accepts a transaction, classifies it and forms the dividend for the back end.
// Depends on pacd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pacd_front
  import pacd_pkg::*;
(
  input  wire logic               in_push,
  output logic                    in_full,
  input  wire logic               in_req_type,
  input  wire logic signed [15:0] in_year,
  input  wire logic [3:0]         in_month,
  input  wire logic [4:0]         in_day,
  input  wire logic signed [24:0] in_day_number,
  input  wire logic [19:0]        epoch,
  output logic                    mid_push,
  output mid_t                    mid_item,
  input  wire logic               mid_full
);

  logic signed [16:0] y_ext, shy;
  logic signed [17:0] ysum;
  logic signed [26:0] dsum;

  always_comb begin
    y_ext = $signed({in_year[15], in_year});
    shy   = (y_ext > 17'sd0) ? y_ext - 17'sd474 : y_ext - 17'sd473;
    ysum  = $signed({shy[16], shy}) + 18'(YEAR_BIAS);
    dsum  = $signed({{2{in_day_number[24]}}, in_day_number})
          - $signed({7'b0, epoch}) + 27'(DAY_BIAS);

    mid_item.req_type = req_t'(in_req_type);
    mid_item.rd       = in_day_number;
    mid_item.month    = in_month;
    mid_item.day      = in_day;
    mid_item.num      = (req_t'(in_req_type) == REQ_TO_DATE) ? dsum[25:0]
                                                             : {9'b0, ysum[16:0]};
  end

  assign in_full  = mid_full;
  assign mid_push = in_push && !mid_full;

endmodule

`default_nettype wire

>>> src/pacd_back.sv
// Back end: pipelined cycle split, year search, month and day recovery.
// Depends on pacd_pkg; pops the middle queue and feeds the result queue.
`timescale 1ns / 1ps
`default_nettype none

module pacd_back
  import pacd_pkg::*;
#(
  parameter int OUT_DEPTH = OUT_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic [19:0] epoch,
  input  wire logic        mid_empty,
  input  wire mid_t        mid_item,
  output logic             mid_pop,
  output logic             res_push,
  output res_t             res_item,
  input  wire logic        res_taken
);

  localparam int CW = $clog2(OUT_DEPTH + 1);
  localparam int NST = 6;

  typedef struct packed {
    req_t               req_type;
    logic signed [24:0] rd;
    logic [3:0]         month;
    logic [4:0]         day;
    logic [25:0]        num;
    logic [5:0]         quo;
    logic [19:0]        rem;
    logic signed [6:0]  ncyc;
    logic signed [27:0] acc;
    logic [20:0]        aux;
    logic [27:0]        numer;
    logic [11:0]        yq;
    logic               leap;
    logic signed [17:0] yr;
    logic [8:0]         doy;
  } work_t;

  work_t          st_r [NST];
  work_t          st_nxt [NST];
  logic [NST-1:0] v_r;
  logic [CW-1:0]  cnt_r, cnt_nxt;

  assign mid_pop = !mid_empty && (cnt_r < CW'(OUT_DEPTH));

  // stage 0: take the transaction
  always_comb begin
    st_nxt[0]          = '0;
    st_nxt[0].req_type = mid_item.req_type;
    st_nxt[0].rd       = mid_item.rd;
    st_nxt[0].month    = mid_item.month;
    st_nxt[0].day      = mid_item.day;
    st_nxt[0].num      = mid_item.num;
  end

  // stage 1: reciprocal estimate of the cycle count
  logic [29:0] s1_py;
  logic [46:0] s1_pc;
  always_comb begin
    s1_py         = 30'(st_r[0].num[16:0]) * 30'(RCP_CYC_Y);
    s1_pc         = 47'(st_r[0].num) * 47'(RCP_CYC_D);
    st_nxt[1]     = st_r[0];
    st_nxt[1].quo = (st_r[0].req_type == REQ_TO_DATE) ? s1_pc[45:40] : s1_py[29:24];
  end

  // stage 2: remainder and one-step correction
  logic [20:0] s2_dv;
  logic [26:0] s2_prod, s2_rw;
  always_comb begin
    st_nxt[2] = st_r[1];
    s2_dv     = (st_r[1].req_type == REQ_TO_DATE) ? 21'(CYC_DAYS) : 21'(CYC_YEARS);
    s2_prod   = 27'(st_r[1].quo) * 27'(s2_dv);
    s2_rw     = {1'b0, st_r[1].num} - s2_prod;
    if (s2_rw >= 27'(s2_dv)) begin
      st_nxt[2].quo = st_r[1].quo + 6'd1;
      s2_rw         = s2_rw - 27'(s2_dv);
    end
    st_nxt[2].rem = s2_rw[19:0];
  end

  // stage 3: cycle offset, year-in-cycle day terms, year estimate
  logic signed [28:0] s3_mc;
  logic [11:0]        s3_r;
  logic [16:0]        s3_r31, s3_r31o;
  logic [52:0]        s3_py;
  always_comb begin
    st_nxt[3]      = st_r[2];
    st_nxt[3].ncyc = $signed({1'b0, st_r[2].quo})
                   - ((st_r[2].req_type == REQ_TO_DATE) ? 7'sd18 : 7'sd12);
    s3_mc          = st_nxt[3].ncyc * 29'sd1029983;
    st_nxt[3].acc  = s3_mc[27:0];
    s3_r           = st_r[2].rem[11:0];
    s3_r31         = 17'(s3_r) * 17'd31;
    s3_r31o        = s3_r31 + 17'd97;
    st_nxt[3].aux  = 21'(s3_r) * 21'd365 + 21'(s3_r31o[16:7]);
    st_nxt[3].leap = (s3_r31[6:0] < 7'd31);
    st_nxt[3].numer = 28'({st_r[2].rem, 7'b0}) + 28'(YEAR_OFS);
    s3_py          = 53'(st_nxt[3].numer) * 53'(RCP_YEAR);
    st_nxt[3].yq   = s3_py[51:40];
  end

  // stage 4: date sum, or year correction
  logic signed [28:0] s4_sum;
  logic signed [9:0]  s4_mo;
  logic [27:0]        s4_py, s4_ry;
  always_comb begin
    st_nxt[4] = st_r[3];
    s4_mo     = month_ofs(st_r[3].month);
    s4_sum    = $signed({9'b0, epoch}) + $signed({st_r[3].acc[27], st_r[3].acc})
              + $signed({8'b0, st_r[3].aux}) + $signed({{19{s4_mo[9]}}, s4_mo})
              + $signed({24'b0, st_r[3].day}) + 29'(FIX_BIAS);
    s4_py     = 28'(st_r[3].yq) * 28'(YEAR_DIV);
    s4_ry     = st_r[3].numer - s4_py;
    if (st_r[3].req_type == REQ_TO_DAY) begin
      st_nxt[4].acc = s4_sum[27:0];
    end
    if (s4_ry >= 28'(YEAR_DIV)) begin
      st_nxt[4].yq = st_r[3].yq + 12'd1;
    end
  end

  // stage 5: year number and day of year
  logic [11:0]        s5_yq;
  logic               s5_wrap;
  logic [11:0]        s5_c;
  logic [16:0]        s5_c31, s5_c31o;
  logic [20:0]        s5_ymid;
  logic signed [17:0] s5_n18;
  logic signed [22:0] s5_doy;
  always_comb begin
    st_nxt[5] = st_r[4];
    // last day of the cycle: the estimate runs one year past the cycle
    s5_yq     = (st_r[4].yq > 12'(CYC_YEARS)) ? 12'(CYC_YEARS) : st_r[4].yq;
    s5_wrap   = (s5_yq == 12'(CYC_YEARS));
    s5_c      = s5_wrap ? 12'd0 : s5_yq;
    s5_c31    = 17'(s5_c) * 17'd31;
    s5_c31o   = s5_c31 + 17'd97;
    s5_ymid   = 21'(s5_c) * 21'd365 + 21'(s5_c31o[16:7]);
    s5_n18    = $signed({{11{st_r[4].ncyc[6]}}, st_r[4].ncyc});
    s5_doy    = $signed({3'b0, st_r[4].rem}) + 23'sd367 - $signed({2'b0, s5_ymid})
              - (s5_wrap ? 23'sd1029983 : 23'sd0);
    if (st_r[4].req_type == REQ_TO_DATE) begin
      st_nxt[5].yr   = 18'sd474 + s5_n18 * 18'sd2820 + $signed({6'b0, s5_yq});
      st_nxt[5].doy  = s5_doy[8:0];
      st_nxt[5].leap = (s5_c31[6:0] < 7'd31);
    end
  end

  // stage 6: month, day of month, range flag; written into the result queue
  logic signed [17:0] s6_yadj;
  logic [3:0]         s6_m;
  logic signed [9:0]  s6_mo;
  logic [8:0]         s6_dom;
  always_comb begin
    s6_yadj  = (st_r[5].yr <= 18'sd0) ? st_r[5].yr - 18'sd1 : st_r[5].yr;
    s6_m     = month_of(st_r[5].doy);
    s6_mo    = month_ofs(s6_m);
    s6_dom   = st_r[5].doy - s6_mo[8:0];
    res_item = '0;
    res_item.leap_year = st_r[5].leap;
    if (st_r[5].req_type == REQ_TO_DATE) begin
      res_item.result_day   = st_r[5].rd;
      res_item.result_year  = s6_yadj[15:0];
      res_item.result_month = s6_m;
      res_item.result_dom   = s6_dom[4:0];
      res_item.range_error  = (s6_yadj < -18'sd32768) || (s6_yadj > 18'sd32767);
    end else begin
      res_item.result_day   = st_r[5].acc[24:0];
    end
  end

  assign res_push = v_r[NST-1];

  always_comb begin
    case ({mid_pop, res_taken})
      2'b10:   cnt_nxt = cnt_r + CW'(1);
      2'b01:   cnt_nxt = cnt_r - CW'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r   <= '0;
      cnt_r <= '0;
    end else begin
      v_r   <= {v_r[NST-2:0], mid_pop};
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NST; i++) begin
      st_r[i] <= st_nxt[i];
    end
  end

  a_credit: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(OUT_DEPTH))
    else $error("result credit overrun");

  a_inflight: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(v_r) <= int'(cnt_r))
    else $error("pipeline holds more than the credit count");

  a_cycle_rem: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[2] |-> (st_r[2].rem < ((st_r[2].req_type == REQ_TO_DATE) ?
                               20'(CYC_DAYS) : 20'(CYC_YEARS))))
    else $error("cycle remainder not reduced");

  a_doy: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r[5] && st_r[5].req_type == REQ_TO_DATE) |->
      (st_r[5].doy >= 9'd1 && st_r[5].doy <= 9'd366))
    else $error("day of year out of range");

endmodule

`default_nettype wire

>>> src/persian_arithmetic_date_convert.sv
// Arithmetic Persian calendar converter, top level.
// Usage: push a transaction when full is low; req_type 0 turns year, month and
// day into a running day number, req_type 1 turns a running day number into
// year, month and day. Each transaction gives exactly one result, in order.
// Results wait in a queue: while empty is low the oldest is on the out_ ports
// and is taken with pop. cfg_we writes epoch_day (day number of 1/1/1); write
// it only with no transaction in flight.
// Throughput: one transaction per cycle while full is low. Each transaction passes
// the front queue and then the six-stage divide pipeline in the back end before
// it reaches the result queue. Reset empties both queues and loads epoch_day
// with 226896. When the receiver stalls the result queue fills, the back end
// stops taking from the front queue once its credit for result slots is spent,
// and full rises when the front queue is also full.
// Depends on pacd_pkg, pacd_front, pacd_fifo, pacd_back.
`timescale 1ns / 1ps
`default_nettype none

module persian_arithmetic_date_convert
  import pacd_pkg::*;
#(
  parameter int MID_DEPTH = MID_DEPTH_DEF,
  parameter int OUT_DEPTH = OUT_DEPTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic [19:0]        cfg_data,
  input  wire logic               in_push,
  output logic                    in_full,
  input  wire logic               in_req_type,
  input  wire logic signed [15:0] in_year,
  input  wire logic [3:0]         in_month,
  input  wire logic [4:0]         in_day,
  input  wire logic signed [24:0] in_day_number,
  output logic                    out_empty,
  input  wire logic               out_pop,
  output logic signed [24:0]      out_result_day,
  output logic signed [15:0]      out_result_year,
  output logic [3:0]              out_result_month,
  output logic [4:0]              out_result_dom,
  output logic                    out_leap_year,
  output logic                    out_range_error
);

  logic [19:0] epoch_r;
  logic        mid_push, mid_full, mid_pop, mid_empty;
  mid_t        mid_wr, mid_rd;
  logic        res_push;
  res_t        res_wr, res_rd;
  logic        res_taken;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      epoch_r <= EPOCH_RST;
    end else if (cfg_we) begin
      epoch_r <= cfg_data;
    end
  end

  pacd_front u_front (
    .in_push       (in_push),
    .in_full       (in_full),
    .in_req_type   (in_req_type),
    .in_year       (in_year),
    .in_month      (in_month),
    .in_day        (in_day),
    .in_day_number (in_day_number),
    .epoch         (epoch_r),
    .mid_push      (mid_push),
    .mid_item      (mid_wr),
    .mid_full      (mid_full)
  );

  pacd_fifo #(
    .WIDTH ($bits(mid_t)),
    .DEPTH (MID_DEPTH)
  ) u_mid_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (mid_push),
    .wdata (mid_wr),
    .full  (mid_full),
    .pop   (mid_pop),
    .rdata (mid_rd),
    .empty (mid_empty)
  );

  pacd_back #(
    .OUT_DEPTH (OUT_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .epoch     (epoch_r),
    .mid_empty (mid_empty),
    .mid_item  (mid_rd),
    .mid_pop   (mid_pop),
    .res_push  (res_push),
    .res_item  (res_wr),
    .res_taken (res_taken)
  );

  logic res_full;

  pacd_fifo #(
    .WIDTH ($bits(res_t)),
    .DEPTH (OUT_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res_wr),
    .full  (res_full),
    .pop   (out_pop),
    .rdata (res_rd),
    .empty (out_empty)
  );

  assign res_taken        = out_pop && !out_empty;
  assign out_result_day   = res_rd.result_day;
  assign out_result_year  = res_rd.result_year;
  assign out_result_month = res_rd.result_month;
  assign out_result_dom   = res_rd.result_dom;
  assign out_leap_year    = res_rd.leap_year;
  assign out_range_error  = res_rd.range_error;

  a_res_room: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> !res_full)
    else $error("result queue full on write");

  a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |-> (mid_empty && !res_push))
    else $error("configuration write with transactions in flight");

  a_fill_order: assert property (@(posedge clk) disable iff (!rst_n)
    (mid_push && mid_empty) |=> !mid_empty)
    else $error("front queue lost a transaction");

endmodule

`default_nettype wire

>>> tb/sv/persian_arithmetic_date_convert_chk.sv
// Checker for the Persian arithmetic calendar converter: watches the input,
// config and result channels, predicts each result and compares field by field.
// Depends on pacd_pkg.
`timescale 1ns / 1ps

module persian_arithmetic_date_convert_chk
  import pacd_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [19:0]        cfg_data,
  input  logic               in_push,
  input  logic               in_full,
  input  logic               in_req_type,
  input  logic signed [15:0] in_year,
  input  logic [3:0]         in_month,
  input  logic [4:0]         in_day,
  input  logic signed [24:0] in_day_number,
  input  logic               out_empty,
  input  logic               out_pop,
  input  logic signed [24:0] out_result_day,
  input  logic signed [15:0] out_result_year,
  input  logic [3:0]         out_result_month,
  input  logic [4:0]         out_result_dom,
  input  logic               out_leap_year,
  input  logic               out_range_error,
  output int                 n_errors,
  output int                 n_pending
);

  longint epoch;
  res_t   conv_q[$];

  function automatic longint fl_div(longint a, longint b);
    longint q;
    q = a / b;
    if ((a % b) != 0 && a < 0) q--;
    return q;
  endfunction

  function automatic longint fl_mod(longint a, longint b);
    return a - b * fl_div(a, b);
  endfunction

  function automatic longint cyc_year(longint y);
    return fl_mod(y - ((y > 0) ? 474 : 473), 2820) + 474;
  endfunction

  function automatic logic is_leap(longint y);
    return fl_mod((cyc_year(y) + 38) * 31, 128) < 31;
  endfunction

  function automatic longint date_to_day(longint y, longint m, longint d);
    longint s, cy, rd;
    s  = y - ((y > 0) ? 474 : 473);
    cy = fl_mod(s, 2820) + 474;
    rd = epoch - 1 + 64'sd1029983 * fl_div(s, 2820) + 365 * (cy - 1)
         + fl_div(31 * cy - 5, 128);
    rd += (m <= 7) ? 31 * (m - 1) : 30 * (m - 1) + 6;
    return rd + d;
  endfunction

  function automatic res_t convert(logic rt, logic signed [15:0] y, logic [3:0] m,
                                   logic [4:0] d, logic signed [24:0] dn);
    res_t   r;
    longint rd, d0, d1, yc, yr, doy, mo, dom;
    r = '0;
    if (req_t'(rt) == REQ_TO_DAY) begin
      rd = date_to_day(longint'(y), longint'(m), longint'(d));
      r.result_day = rd[24:0];
      r.leap_year  = is_leap(longint'(y));
    end else begin
      rd = longint'(dn);
      d0 = rd - date_to_day(475, 1, 1);
      d1 = fl_mod(d0, 1029983);
      yc = (d1 == 1029982) ? 2820 : fl_div(128 * d1 + 46878, 46751);
      yr = 474 + 2820 * fl_div(d0, 1029983) + yc;
      if (yr <= 0) yr--;
      doy = 1 + rd - date_to_day(yr, 1, 1);
      mo  = (doy <= 186) ? fl_div(doy + 30, 31) : fl_div(doy + 23, 30);
      dom = rd - date_to_day(yr, mo, 1) + 1;
      r.result_day   = rd[24:0];
      r.result_year  = yr[15:0];
      r.result_month = mo[3:0];
      r.result_dom   = dom[4:0];
      r.leap_year    = is_leap(yr);
      r.range_error  = (yr < -32768 || yr > 32767);
    end
    return r;
  endfunction

  always @(posedge clk) begin
    res_t e;
    int   errs;
    errs = 0;
    if (!rst_n) begin
      epoch     <= 226896;
      n_errors  <= 0;
      n_pending <= 0;
      conv_q.delete();
    end else begin
      if (cfg_we) epoch <= longint'(cfg_data);
      if (out_pop && !out_empty) begin
        if (conv_q.size() == 0) begin
          $error("result transaction with nothing expected");
          errs++;
        end else begin
          e = conv_q.pop_front();
          if (out_result_day !== e.result_day) begin
            $error("result_day exp %0d got %0d", e.result_day, out_result_day);
            errs++;
          end
          if (out_result_year !== e.result_year) begin
            $error("result_year exp %0d got %0d", e.result_year, out_result_year);
            errs++;
          end
          if (out_result_month !== e.result_month) begin
            $error("result_month exp %0d got %0d", e.result_month, out_result_month);
            errs++;
          end
          if (out_result_dom !== e.result_dom) begin
            $error("result_dom exp %0d got %0d", e.result_dom, out_result_dom);
            errs++;
          end
          if (out_leap_year !== e.leap_year) begin
            $error("leap_year exp %0d got %0d", e.leap_year, out_leap_year);
            errs++;
          end
          if (out_range_error !== e.range_error) begin
            $error("range_error exp %0d got %0d", e.range_error, out_range_error);
            errs++;
          end
        end
      end
      if (in_push && !in_full)
        conv_q.push_back(convert(in_req_type, in_year, in_month, in_day, in_day_number));
      n_errors  <= n_errors + errs;
      n_pending <= conv_q.size();
    end
  end

endmodule

>>> tb/sv/persian_arithmetic_date_convert_tb.sv
// Testbench top for the Persian arithmetic calendar converter: clock, reset,
// stimulus with bursts and stalls, epoch settings and the verdict.
// Depends on pacd_pkg, persian_arithmetic_date_convert, persian_arithmetic_date_convert_chk.
`timescale 1ns / 1ps

module persian_arithmetic_date_convert_tb;
  import pacd_pkg::*;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_we = 1'b0;
  logic [19:0]        cfg_data = '0;
  logic               in_push = 1'b0;
  logic               in_full;
  logic               in_req_type = 1'b0;
  logic signed [15:0] in_year = '0;
  logic [3:0]         in_month = '0;
  logic [4:0]         in_day = '0;
  logic signed [24:0] in_day_number = '0;
  logic               out_empty;
  logic               out_pop = 1'b0;
  logic signed [24:0] out_result_day;
  logic signed [15:0] out_result_year;
  logic [3:0]         out_result_month;
  logic [4:0]         out_result_dom;
  logic               out_leap_year;
  logic               out_range_error;
  int                 n_errors;
  int                 n_pending;

  logic               rx_stall_on = 1'b0;
  logic               tx_gaps_on = 1'b0;
  logic               hold_req = 1'b0;
  logic               hold_done = 1'b0;
  int                 hold_cnt = 0;
  int                 idle_cycles = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  persian_arithmetic_date_convert u_top (.*);

  persian_arithmetic_date_convert_chk u_chk (.*);

  always @(posedge clk) begin
    if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_pop  <= 1'b0;
    end else if (hold_req && !hold_done) begin
      hold_cnt  <= 120;
      hold_done <= 1'b1;
      out_pop   <= 1'b0;
    end else begin
      out_pop <= rx_stall_on ? ($urandom_range(0, 3) != 0) : 1'b1;
    end
  end

  always @(posedge clk) begin
    if ((in_push && !in_full) || (out_pop && !out_empty) || cfg_we || !rst_n)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 5000) begin
      $display("[persian_arithmetic_date_convert] ERROR");
      $finish;
    end
  end

  task automatic offer(logic rt, logic signed [15:0] y, logic [3:0] m, logic [4:0] d,
                       logic signed [24:0] dn);
    logic taken;
    in_push       <= 1'b1;
    in_req_type   <= rt;
    in_year       <= y;
    in_month      <= m;
    in_day        <= d;
    in_day_number <= dn;
    forever begin
      @(negedge clk);
      taken = !in_full;
      @(posedge clk);
      if (taken) break;
    end
  endtask

  task automatic idle_gap(int n);
    in_push <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic drain;
    in_push <= 1'b0;
    @(posedge clk);
    while (n_pending != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic set_epoch(logic [19:0] v);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we   <= 1'b0;
  endtask

  task automatic random_items(int n);
    int burst;
    int sel;
    logic signed [24:0] dn;
    burst = $urandom_range(1, 20);
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(0, 9);
      if (sel < 4) begin
        offer(REQ_TO_DAY, 16'($urandom_range(0, 8000) - 4000), 4'($urandom_range(1, 12)),
              5'($urandom_range(1, 31)), 25'($urandom));
      end else if (sel < 8) begin
        dn = 25'(int'(u_chk.epoch) + int'($urandom_range(0, 3000000)) - 1500000);
        offer(REQ_TO_DATE, 16'($urandom), 4'($urandom), 5'($urandom), dn);
      end else begin
        offer(1'($urandom), 16'($urandom), 4'($urandom), 5'($urandom), 25'($urandom));
      end
      burst--;
      if (burst == 0) begin
        if (tx_gaps_on) idle_gap($urandom_range(1, 8));
        burst = $urandom_range(1, 20);
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    offer(REQ_TO_DAY, 16'sd1, 4'd1, 5'd1, '0);
    offer(REQ_TO_DAY, 16'sd0, 4'd1, 5'd1, '0);
    offer(REQ_TO_DAY, -16'sd1, 4'd12, 5'd30, '0);
    offer(REQ_TO_DAY, -16'sd32768, 4'd1, 5'd1, '1);
    offer(REQ_TO_DAY, 16'sd32767, 4'd12, 5'd31, '0);
    offer(REQ_TO_DAY, 16'sd1403, 4'd0, 5'd0, '0);
    offer(REQ_TO_DAY, 16'sd1403, 4'd13, 5'd31, '0);
    offer(REQ_TO_DAY, 16'sd1403, 4'd15, 5'd31, '0);
    offer(REQ_TO_DAY, 16'sd475, 4'd7, 5'd31, '0);
    offer(REQ_TO_DAY, 16'sd3294, 4'd8, 5'd15, '0);
    offer(REQ_TO_DATE, '0, '0, '0, 25'sd226896);
    offer(REQ_TO_DATE, '1, '1, '1, 25'sd226895);
    offer(REQ_TO_DATE, '0, '0, '0, -25'sd16777216);
    offer(REQ_TO_DATE, '0, '0, '0, 25'sd16777215);
    offer(REQ_TO_DATE, '0, '0, '0, 25'sd0);
    offer(REQ_TO_DATE, '0, '0, '0, -25'sd1);
    offer(REQ_TO_DATE, '0, '0, '0, 25'sd226896 + 25'sd1029982);
    offer(REQ_TO_DATE, '0, '0, '0, 25'sd399949 + 25'sd1029982);
    offer(REQ_TO_DATE, '0, '0, '0, 25'sd399949 + 25'sd1029981);
    offer(REQ_TO_DATE, '0, '0, '0, 25'sd732000);
    drain();

    random_items(200);
    drain();

    set_epoch(20'd0);
    tx_gaps_on  <= 1'b1;
    rx_stall_on <= 1'b1;
    random_items(250);
    drain();

    set_epoch(20'hFFFFF);
    hold_req <= 1'b1;
    random_items(250);
    drain();

    set_epoch(20'($urandom));
    tx_gaps_on <= 1'b0;
    random_items(150);
    tx_gaps_on <= 1'b1;
    random_items(150);
    drain();

    if (n_errors == 0)
      $display("[persian_arithmetic_date_convert] OK");
    else
      $display("[persian_arithmetic_date_convert] ERROR");
    $finish;
  end

endmodule
